@@ rtl/s45l_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s45l_pkg: shared types and constants of the 4-to-5 line scaler
// Holds the blend weights per group position and the result item layout.
// ----------------------------------------------------------------------------
package s45l_pkg;

	localparam int PIX_W   = 8;
	localparam int PHASE_W = 2;
	localparam int PROD_W  = 2 * PIX_W;

	typedef logic [PIX_W-1:0]   pix_t;
	typedef logic [PHASE_W-1:0] phase_t;
	typedef logic [PROD_W-1:0]  prod_t;

	// Weight of the previous pixel, by phase of the incoming pixel; the
	// incoming pixel takes the complement to 256. Phase 0 is the blend that
	// closes the previous group.
	localparam pix_t WEIGHT_PREV [4] = '{8'd205, 8'd51, 8'd102, 8'd154};
	localparam prod_t ROUND_HALF     = 16'd128;
	localparam phase_t PHASE_FIRST   = 2'd0;
	localparam phase_t PHASE_LAST    = 2'd3;

	typedef struct packed {
		logic misaligned;
		logic line_done;
		logic last_out;
		pix_t pixel_out;
	} result_t;

endpackage

@@ rtl/scale_4_to_5_line.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scale_4_to_5_line: horizontal 4-to-5 pixel line upscaler
// Turns each group of four source pixels into five output pixels: a copy
// of the first and four rounded two-tap blends of neighboring pixels.
// ----------------------------------------------------------------------------
// Usage: feed one source pixel per item on the s_ side, with s_tlast on the
// final pixel of a line. One item enters per cycle while the stage register
// is empty or its item is done; an item that yields one result leaves the
// stage register when that result loads, an item that yields two results
// (a group start other than a line's first pixel, or a line end at any
// position other than a group start) holds the stage register until both
// have loaded, because the result register moves one item per cycle while
// the sink does not stall it. A line end at a length that is not a multiple
// of four closes the line with a copy of the last pixel and raises
// misaligned on that final result.
module scale_4_to_5_line (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] pixel_in
	input  logic       s_tlast,   // line_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] pixel_out
	output logic       m_tlast,   // last_out
	output logic [1:0] m_tuser    // [0] line_done, [1] misaligned
);
	import s45l_pkg::*;

	// line state, updated as each item is accepted
	phase_t phase_q;
	pix_t   prev_q;
	logic   line_start_q;

	// stage register: one accepted item with the state it saw
	logic   valid_s1;
	logic   sel_s1;        // second result of this item is next
	pix_t   pix_s1;
	pix_t   prev_s1;
	phase_t phase_s1;
	logic   start_s1;
	logic   end_s1;

	// result register
	logic    out_valid_q;
	result_t out_q;

	logic    in_acc;
	logic    load_out;
	logic    two_res;
	logic    item_done;
	pix_t    w_prev;
	pix_t    w_cur;
	prod_t   prod_prev;
	prod_t   prod_cur;
	prod_t   blend_sum;
	pix_t    blend_pix;
	result_t res0;
	result_t res1;

	assign in_acc = s_tvalid && s_tready;

	// Two-tap blend: weights sum to 256, so the rounded sum fits 16 bits.
	always_comb begin
		w_prev    = WEIGHT_PREV[phase_s1];
		w_cur     = pix_t'(9'd256 - {1'b0, w_prev});
		prod_prev = prod_t'(prev_s1) * prod_t'(w_prev);
		prod_cur  = prod_t'(pix_s1) * prod_t'(w_cur);
		blend_sum = prod_prev + prod_cur + ROUND_HALF;
		blend_pix = blend_sum[PROD_W-1:PIX_W];
	end

	// Build the one or two results of the item in the stage register.
	always_comb begin
		res0    = '0;
		res1    = '0;
		two_res = 1'b0;
		res1.pixel_out = pix_s1;
		res1.last_out  = 1'b1;
		if (phase_s1 == PHASE_FIRST) begin
			// close the previous group unless at line start, then copy the group's first pixel
			res1.line_done  = end_s1;
			res1.misaligned = end_s1;
			if (start_s1) begin
				res0 = res1;
			end else begin
				res0.pixel_out = blend_pix;
				two_res        = 1'b1;
			end
		end else begin
			res0.pixel_out  = blend_pix;
			res0.last_out   = !end_s1;
			res1.line_done  = 1'b1;
			res1.misaligned = (phase_s1 != PHASE_LAST);
			two_res         = end_s1;
		end
	end

	assign load_out  = valid_s1 && (!out_valid_q || m_tready);
	assign item_done = load_out && (sel_s1 || !two_res);
	assign s_tready  = !valid_s1 || item_done;

	// Line state: track position within the group and the previous pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PHASE_FIRST;
			prev_q       <= '0;
			line_start_q <= 1'b1;
		end else if (in_acc) begin
			prev_q <= s_tdata;
			if (s_tlast) begin
				phase_q      <= PHASE_FIRST;
				line_start_q <= 1'b1;
			end else begin
				phase_q      <= phase_q + phase_t'(1);
				line_start_q <= 1'b0;
			end
		end
	end

	// Stage register control: hold the item until its last result has moved.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			sel_s1   <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
				sel_s1   <= 1'b0;
			end else if (item_done) begin
				valid_s1 <= 1'b0;
				sel_s1   <= 1'b0;
			end else if (load_out) begin
				sel_s1 <= 1'b1;    // first of two results has gone out
			end
		end
	end

	// Stage payload: capture the pixel along with the state it arrived in.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1   <= s_tdata;
			prev_s1  <= prev_q;
			phase_s1 <= phase_q;
			start_s1 <= line_start_q;
			end_s1   <= s_tlast;
		end
	end

	// Result register: advance when empty or when the sink takes the item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= sel_s1 ? res1 : res0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.pixel_out;
	assign m_tlast  = out_q.last_out;
	assign m_tuser  = {out_q.misaligned, out_q.line_done};

	// The second-result select is only ever set on an item with two results.
	a_sel_two : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && sel_s1) |-> two_res)
		else $error("second result selected on a single-result item");

	// A result that flags line_done always carries last_out.
	a_done_last : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> m_tlast)
		else $error("line_done without last_out");

	// Misalignment is only reported on the line's final pixel.
	a_mis_done : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> m_tuser[0])
		else $error("misaligned without line_done");

	// Input back-pressure only while the stage register is occupied.
	a_ready : assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1)
		else $error("input stalled with empty stage register");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking regression of the 4-to-5 line scaler
// Feeds lines of source pixels with bursty timing, predicts every scaled
// pixel from its own model of the group phase and the rounded blends, and
// checks each output item in order while the output side stalls on its own
// pattern, including long hold-offs that back up the block's input.
// ----------------------------------------------------------------------------
module tb;
	import s45l_pkg::*;

	localparam int ITEM_TARGET = 700;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 10;

	// Weight of the previous pixel by phase of the incoming one; the incoming
	// pixel takes 256 minus this. Phase 0 closes the previous group.
	localparam int PREV_WEIGHT [4] = '{205, 51, 102, 154};

	// Model of the scaler plus the queue of scaled pixels still to come out.
	class scaled_pixel_board;
		phase_t    phase;
		pix_t      prev_pix;
		bit        at_line_start;
		result_t   pending_pixels[$];
		int        error_count;

		function new();
			phase = PHASE_FIRST;
			prev_pix = '0;
			at_line_start = 1'b1;
			error_count = 0;
		endfunction

		function pix_t blend(pix_t a, pix_t b, int wa);
			int sum;
			sum = int'(a) * wa + int'(b) * (256 - wa) + 128;
			return pix_t'(sum >> 8);
		endfunction

		function void add_pixel(pix_t pix, logic last, logic done, logic mis);
			result_t r;
			r.pixel_out = pix;
			r.last_out = last;
			r.line_done = done;
			r.misaligned = mis;
			pending_pixels.push_back(r);
		endfunction

		// Predict the scaled pixels caused by one accepted source pixel.
		function void note_pixel(pix_t pix, logic line_end);
			pix_t mixed;
			mixed = blend(prev_pix, pix, PREV_WEIGHT[phase]);
			if (phase == PHASE_FIRST) begin
				// group start: close the previous group unless at line start, then copy
				if (!at_line_start)
					add_pixel(mixed, 1'b0, 1'b0, 1'b0);
				add_pixel(pix, 1'b1, line_end, line_end);
			end else begin
				add_pixel(mixed, !line_end, 1'b0, 1'b0);
				if (line_end)
					add_pixel(pix, 1'b1, 1'b1, phase != PHASE_LAST);
			end
			prev_pix = pix;
			if (line_end) begin
				phase = PHASE_FIRST;
				at_line_start = 1'b1;
			end else begin
				phase = phase + phase_t'(1);
				at_line_start = 1'b0;
			end
		endfunction

		// Compare one output item against the oldest prediction.
		function void check_pixel(result_t got);
			result_t want;
			if (pending_pixels.size() == 0) begin
				$error("unexpected output item: pixel_out %0d", got.pixel_out);
				error_count++;
				return;
			end
			want = pending_pixels.pop_front();
			if (got.pixel_out !== want.pixel_out) begin
				$error("pixel_out: expected %0d, actual %0d", want.pixel_out, got.pixel_out);
				error_count++;
			end
			if (got.last_out !== want.last_out) begin
				$error("last_out: expected %0b, actual %0b", want.last_out, got.last_out);
				error_count++;
			end
			if (got.line_done !== want.line_done) begin
				$error("line_done: expected %0b, actual %0b", want.line_done, got.line_done);
				error_count++;
			end
			if (got.misaligned !== want.misaligned) begin
				$error("misaligned: expected %0b, actual %0b", want.misaligned, got.misaligned);
				error_count++;
			end
		endfunction

		function int pending();
			return pending_pixels.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic [1:0] m_tuser;

	scaled_pixel_board board = new();

	pix_t line_buf[$];
	int   items_sent = 0;
	int   burst_left = 0;

	// receiver pattern state
	int cycle_count = 0;
	int ready_mode = 0;
	int mode_left = 0;
	int hold_left = 0;

	scale_4_to_5_line dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Offer one source pixel and hold it until the block takes it. Open a
	// random gap between bursts; drop valid only while in a gap.
	task automatic send_pixel(input pix_t pix, input logic line_end);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pix;
		s_tlast <= line_end;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_pixel(pix, line_end);
		items_sent++;
		burst_left--;
	endtask

	// Send the pixels held in line_buf as one line.
	task automatic send_line();
		for (int i = 0; i < line_buf.size(); i++)
			send_pixel(line_buf[i], i == line_buf.size() - 1);
	endtask

	// Receiver: switch between stall patterns, and twice hold off for a long
	// stretch so the block fills up and stalls its input.
	always @(posedge clk) begin
		cycle_count++;
		if (mode_left == 0) begin
			ready_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(32, 96);
		end
		mode_left--;
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (cycle_count == 400 || cycle_count == 1000) begin
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			case (ready_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 9) < 7);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (cycle_count % 3 == 0);
			endcase
		end
	end

	// Check every output item at the edge that accepts it.
	always @(posedge clk) begin
		result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.pixel_out = m_tdata;
			got.last_out = m_tlast;
			got.line_done = m_tuser[0];
			got.misaligned = m_tuser[1];
			board.check_pixel(got);
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#400000;
		$display("scale_4_to_5_line regression: fail");
		$finish;
	end

	initial begin
		int len;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// aligned line with alternating extremes
		line_buf = '{8'd0, 8'd255, 8'd0, 8'd255};
		send_line();
		// two groups: full white into full black across the group seam
		line_buf = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0};
		send_line();
		// line of one pixel: ends at a group start with no blend before it
		line_buf = '{8'd255};
		send_line();
		// ends at the second and third position of a group
		line_buf = '{8'd0, 8'd255};
		send_line();
		line_buf = '{8'd255, 8'd0, 8'd255};
		send_line();
		// ends at the start of a second group: seam blend, then final copy
		line_buf = '{8'd17, 8'd200, 8'd99, 8'd255, 8'd1};
		send_line();

		// Random lines: mostly whole groups, some cut short anywhere.
		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 19) < 17)
				len = 4 * $urandom_range(1, 12);
			else
				len = $urandom_range(1, 19);
			line_buf = {};
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(0, 11))
					0: line_buf.push_back(8'd0);
					1: line_buf.push_back(8'd255);
					default: line_buf.push_back(pix_t'($urandom));
				endcase
			end
			send_line();
		end
		s_tvalid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.error_count == 0 && board.pending() == 0)
			$display("scale_4_to_5_line regression: pass");
		else
			$display("scale_4_to_5_line regression: fail");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/s45l_pkg.sv
rtl/scale_4_to_5_line.sv
tb/tb.sv
